FILE: sv/rxdr_pkg.sv
// ----------------------------------------------------------------------------
// rxdr_pkg
// Types and fixed widths shared by the receive descriptor ring.
// ----------------------------------------------------------------------------
package rxdr_pkg;

	localparam int LEN_W  = 10;
	localparam int SLOT_W = 4;
	localparam int OVW_W  = 16;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_FETCH  = 1'b1;

	typedef struct packed {
		logic             op;
		logic [LEN_W-1:0] packet_length;
		logic [LEN_W-1:0] max_length;
	} rxdr_in_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] read_slot;
		logic [LEN_W-1:0]  read_length;
		logic [SLOT_W-1:0] fill_slot;
		logic [OVW_W-1:0]  overwrite_count;
	} rxdr_out_t;

endpackage

FILE: sv/rxdr_len_store.sv
// ----------------------------------------------------------------------------
// rxdr_len_store
// Slot length memory: one write port, one registered read port. Per-slot
// valid flags make never-written or reset slots read back as zero.
// ----------------------------------------------------------------------------
module rxdr_len_store #(
	parameter int SLOT_COUNT = 16,
	parameter int IDX_W      = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [IDX_W-1:0]          rd_addr,
	output logic [rxdr_pkg::LEN_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_addr,
	input  logic [rxdr_pkg::LEN_W-1:0] wr_data
);
	import rxdr_pkg::*;

	logic [LEN_W-1:0]      mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] valid_q;
	logic [LEN_W-1:0]      rd_data_s1;
	logic                  rd_valid_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_s1 <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_s1 ? rd_data_s1 : '0;

endmodule

FILE: sv/rx_packet_descriptor_ring_top.sv
// ----------------------------------------------------------------------------
// rx_packet_descriptor_ring_top
// Receive descriptor ring of packet lengths with head/tail pointers.
//
//   channel   dir  handshake           word
//   in_data   in   in_valid/in_ready   rxdr_in_t  (op, lengths)
//   out_data  out  out_valid/out_ready rxdr_out_t (one result per input word)
//
// Record: from accept to result the steps are read, modify/write, result.
// Fetch: one length memory read per slot visited (those skipped plus the one
// returned). An empty ring fetch goes straight to the result.
// Reset clears pointers, counter and slot valid flags at once; no sweep.
// A waiting result does not block acceptance of the next input word.
// ----------------------------------------------------------------------------
module rx_packet_descriptor_ring_top #(
	parameter int SLOT_COUNT       = 16,
	parameter int MAX_PACKET_BYTES = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rxdr_pkg::rxdr_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rxdr_pkg::rxdr_out_t out_data
);
	import rxdr_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t           st_q;
	logic             op_q;
	logic [LEN_W-1:0] plen_q;
	logic [LEN_W-1:0] maxlen_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [OVW_W-1:0] ovw_q;
	rxdr_out_t        res_q;
	rxdr_out_t        out_q;
	logic             out_valid_q;

	logic             accept;
	logic             out_load;
	logic [IDX_W-1:0] rd_addr;
	logic [LEN_W-1:0] rd_len;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [LEN_W-1:0] wr_data;
	logic [IDX_W-1:0] head_nxt;
	logic [IDX_W-1:0] tail_nxt;
	logic [IDX_W-1:0] head_new;
	logic [OVW_W-1:0] ovw_new;
	logic [LEN_W-1:0] plen_sat;
	logic             fits;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = (st_q == ST_IDLE);
	assign out_load = (st_q == ST_DONE) && (!out_valid_q || out_ready);

	assign head_nxt = ring_next(head_q);
	assign tail_nxt = ring_next(tail_q);
	assign head_new = (head_nxt != tail_q) ? head_nxt : head_q;
	assign ovw_new  = (rd_len != '0) ? ovw_q + 1'b1 : ovw_q;
	assign plen_sat = (32'(plen_q) > 32'(MAX_PACKET_BYTES)) ?
	                  LEN_W'(MAX_PACKET_BYTES) : plen_q;
	assign fits     = (rd_len <= maxlen_q);

	// read address: head for a record, tail (or the slot after it) for a fetch
	always_comb begin
		rd_addr = head_q;
		if (st_q == ST_IDLE && in_data.op == OP_FETCH) begin
			rd_addr = tail_q;
		end else if (st_q == ST_LOOK && op_q == OP_FETCH) begin
			rd_addr = tail_nxt;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = plen_sat;
		if (st_q == ST_LOOK) begin
			if (op_q == OP_RECORD) begin
				wr_en = 1'b1;
			end else if (fits) begin
				wr_en   = 1'b1;
				wr_addr = tail_q;
				wr_data = '0;
			end
		end
	end

	rxdr_len_store #(
		.SLOT_COUNT (SLOT_COUNT),
		.IDX_W      (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_len),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= in_data.op;
			plen_q   <= in_data.packet_length;
			maxlen_q <= in_data.max_length;
		end
		if (out_load) begin
			out_q <= res_q;
		end
		unique case (st_q)
			ST_IDLE: begin
				res_q <= '{found: 1'b0, read_slot: '0, read_length: '0,
				           fill_slot: SLOT_W'(head_q), overwrite_count: ovw_q};
			end
			ST_LOOK: begin
				if (op_q == OP_RECORD) begin
					res_q.fill_slot       <= SLOT_W'(head_new);
					res_q.overwrite_count <= ovw_new;
				end else if (fits) begin
					res_q.found       <= 1'b1;
					res_q.read_slot   <= SLOT_W'(tail_q);
					res_q.read_length <= rd_len;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			ovw_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.op == OP_FETCH && head_q == tail_q) begin
							st_q <= ST_DONE;
						end else begin
							st_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					if (op_q == OP_RECORD) begin
						head_q <= head_new;
						ovw_q  <= ovw_new;
						st_q   <= ST_DONE;
					end else begin
						// oversized slots are consumed but keep their length
						tail_q <= tail_nxt;
						if (fits || tail_nxt == head_q) begin
							st_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: sv/rxdr_checker.sv
// ----------------------------------------------------------------------------
// rxdr_checker
// Port-level checks on the descriptor ring, bound to the top level.
// ----------------------------------------------------------------------------
module rxdr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input rxdr_pkg::rxdr_in_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input rxdr_pkg::rxdr_out_t out_data
);
	import rxdr_pkg::*;

	// an offered input word holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input word changed while waiting");

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// one word in flight: the port closes after each accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while previous word still in work");

	// no packet returned means slot and length read as zero
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |->
			out_data.read_length == '0 && out_data.read_slot == '0)
		else $error("empty result carries slot or length");

	// a result never shows up without an earlier input word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

endmodule

bind rx_packet_descriptor_ring_top rxdr_checker u_rxdr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
